// ===== hdl/block_chain_free_list_allocator_unit_macros.svh =====
`ifndef BLOCK_CHAIN_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_CHAIN_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BCFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define BCFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== hdl/bcfl_pkg.sv =====
package bcfl_pkg;

    localparam int NUM_BLOCKS  = 1024;
    localparam int BLOCK_WORDS = 256;

    localparam int BLK_W    = $clog2(NUM_BLOCKS);
    localparam int CNT_W    = 11;
    localparam int WORDS_W  = 9;
    localparam int LEN_W    = 20;
    localparam int BW_SHIFT = $clog2(BLOCK_WORDS);
    localparam int NEED_W   = LEN_W - BW_SHIFT + 1;
    localparam int MARK_W   = CNT_W + WORDS_W;
    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INSPECT = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_SHORT = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_AWALK,
        S_AEND,
        S_RWALK,
        S_RLINK,
        S_INSP
    } t_bstate;

    typedef struct packed {
        logic [1:0]       operation;
        logic [LEN_W-1:0] length_words;
        logic [9:0]       first_block;
        logic [10:0]      chain_blocks;
    } t_req;

    typedef struct packed {
        logic [9:0]  start_block;
        logic [10:0] blocks_taken;
        logic [8:0]  words_used;
        logic [10:0] chain_position;
        logic [9:0]  next_of_block;
        logic [10:0] blocks_free;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        t_op                op;
        logic               zero;
        logic [NEED_W-1:0]  need;
        logic [WORDS_W-1:0] rest;
        logic [BLK_W-1:0]   first;
        logic [CNT_W-1:0]   count;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]   pos;
        logic [WORDS_W-1:0] used;
    } t_marks;

endpackage

// ===== hdl/bcfl_if.sv =====
interface bcfl_req_if import bcfl_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bcfl_rsp_if import bcfl_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/block_chain_free_list_allocator_unit.sv =====
// Each request is answered with a registered result. Allocate and release walk the
// next-pointer memory one block per cycle, inspect reads one block, and a rejected or
// unused request is answered without a walk. The sequencer holds each request until it
// is answered; a two-entry queue takes requests ahead.
// Reset clears control state and then runs a pass over all 1024 blocks that rebuilds the
// free list and clears the block marks; no request is accepted during that pass.
module block_chain_free_list_allocator_unit import bcfl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcfl_req_if.sink   i_req,
    bcfl_rsp_if.source o_rsp
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    logic clearing;
    t_cmd cmd_in;
    t_cmd cmd_out;

    bcfl_front u_front (
        .i_req      (i_req),
        .i_full     (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    bcfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (cmd_out),
        .i_pop   (pop)
    );

    bcfl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

// ===== hdl/bcfl_ram.sv =====
module bcfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bcfl_front.sv =====
module bcfl_front import bcfl_pkg::*; (
    bcfl_req_if.sink i_req,
    input  logic     i_full,
    input  logic     i_clearing,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [BW_SHIFT-1:0] len_low;

    assign len_low     = i_req.payload.length_words[BW_SHIFT-1:0];
    assign i_req.ready = !i_full && !i_clearing;
    assign o_push      = i_req.valid && i_req.ready;

    // Blocks needed is the length rounded up to whole blocks; the last
    // block holds the remainder, or a full block when there is none.
    always_comb begin
        o_cmd.op    = t_op'(i_req.payload.operation);
        o_cmd.first = BLK_W'(i_req.payload.first_block);
        o_cmd.count = i_req.payload.chain_blocks;
        o_cmd.need  = NEED_W'(i_req.payload.length_words >> BW_SHIFT)
                    + NEED_W'(|len_low);
        o_cmd.rest  = (len_low == '0) ? WORDS_W'(BLOCK_WORDS) : WORDS_W'(len_low);
        case (o_cmd.op)
            OP_ALLOC:   o_cmd.zero = (i_req.payload.length_words == '0);
            OP_RELEASE: o_cmd.zero = (i_req.payload.chain_blocks == '0);
            default:    o_cmd.zero = 1'b0;
        endcase
    end

endmodule

// ===== hdl/bcfl_queue.sv =====
module bcfl_queue import bcfl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/bcfl_back.sv =====
module bcfl_back import bcfl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_clearing,
    bcfl_rsp_if.source o_rsp
);

    t_bstate          r_state;
    t_bstate          n_state;
    logic [BLK_W-1:0] r_clr;
    logic [BLK_W-1:0] r_head;
    logic [BLK_W-1:0] r_tail;
    logic [BLK_W-1:0] r_last;
    logic [CNT_W-1:0] r_free;
    logic [CNT_W-1:0] r_k;
    t_cmd             r_itm;
    t_rsp             r_rsp;
    logic             r_out_valid;

    logic             nxt_we;
    logic [BLK_W-1:0] nxt_wa;
    logic [BLK_W-1:0] nxt_wd;
    logic [BLK_W-1:0] nxt_ra;
    logic [BLK_W-1:0] nxt_rd;
    logic             mk_we;
    logic [BLK_W-1:0] mk_wa;
    t_marks           mk_wd;
    logic [BLK_W-1:0] mk_ra;
    logic [MARK_W-1:0] mk_rd_raw;
    t_marks           mk_rd;

    logic             out_free;
    logic             start;
    logic             alloc_ok;
    logic             rel_ok;
    logic             clr_last;
    logic [CNT_W-1:0] k_nxt;
    logic             rsp_load;
    t_rsp             rsp_next;

    bcfl_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_wa),
        .i_wdata (nxt_wd),
        .i_raddr (nxt_ra),
        .o_rdata (nxt_rd)
    );

    bcfl_ram #(.WIDTH(MARK_W), .DEPTH(NUM_BLOCKS)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mk_we),
        .i_waddr (mk_wa),
        .i_wdata (MARK_W'(mk_wd)),
        .i_raddr (mk_ra),
        .o_rdata (mk_rd_raw)
    );

    assign mk_rd       = t_marks'(mk_rd_raw);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign start       = (r_state == S_IDLE) && i_q_valid && out_free;
    assign alloc_ok    = !i_cmd.zero && (i_cmd.need <= NEED_W'(r_free));
    assign rel_ok      = !i_cmd.zero && (i_cmd.count <= CNT_W'(NUM_BLOCKS) - r_free);
    assign clr_last    = (r_clr == BLK_W'(NUM_BLOCKS - 1));
    assign k_nxt       = r_k + 1'b1;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload = r_rsp;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.op)
                        OP_ALLOC: begin
                            if (alloc_ok) begin
                                n_state = (i_cmd.need == NEED_W'(1)) ? S_AEND : S_AWALK;
                            end
                        end
                        OP_RELEASE: begin
                            if (rel_ok) begin
                                n_state = (i_cmd.count == CNT_W'(1)) ? S_RLINK : S_RWALK;
                            end
                        end
                        OP_INSPECT: n_state = S_INSP;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_AWALK: begin
                if (NEED_W'(k_nxt) == r_itm.need) begin
                    n_state = S_AEND;
                end
            end
            S_RWALK: begin
                if (k_nxt == r_itm.count) begin
                    n_state = S_RLINK;
                end
            end
            S_AEND:  n_state = S_IDLE;
            S_RLINK: n_state = S_IDLE;
            S_INSP:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        nxt_we   = 1'b0;
        nxt_wa   = r_tail;
        nxt_wd   = r_itm.first;
        nxt_ra   = r_head;
        mk_we    = 1'b0;
        mk_wa    = r_head;
        mk_wd    = '0;
        mk_ra    = i_cmd.first;
        o_pop    = 1'b0;
        rsp_load = 1'b0;
        rsp_next = '0;
        rsp_next.blocks_free = r_free;
        unique case (r_state)
            S_CLEAR: begin
                nxt_we = 1'b1;
                nxt_wa = r_clr;
                nxt_wd = clr_last ? '0 : r_clr + 1'b1;
                mk_we  = 1'b1;
                mk_wa  = r_clr;
            end
            S_IDLE: begin
                o_pop = start;
                if (start) begin
                    unique case (i_cmd.op)
                        OP_ALLOC: begin
                            if (alloc_ok) begin
                                mk_we       = 1'b1;
                                mk_wa       = r_head;
                                mk_wd.pos   = CNT_W'(1);
                                mk_wd.used  = (i_cmd.need == NEED_W'(1)) ? i_cmd.rest
                                            : WORDS_W'(BLOCK_WORDS);
                                nxt_ra      = r_head;
                            end else begin
                                rsp_load        = 1'b1;
                                rsp_next.status = i_cmd.zero ? ST_ZERO : ST_SHORT;
                            end
                        end
                        OP_RELEASE: begin
                            if (rel_ok) begin
                                mk_we  = 1'b1;
                                mk_wa  = i_cmd.first;
                                nxt_ra = i_cmd.first;
                            end else begin
                                rsp_load        = 1'b1;
                                rsp_next.status = i_cmd.zero ? ST_ZERO : ST_OVER;
                            end
                        end
                        OP_INSPECT: begin
                            nxt_ra = i_cmd.first;
                        end
                        default: begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            S_AWALK: begin
                mk_we      = 1'b1;
                mk_wa      = nxt_rd;
                mk_wd.pos  = k_nxt;
                mk_wd.used = (NEED_W'(k_nxt) == r_itm.need) ? r_itm.rest
                           : WORDS_W'(BLOCK_WORDS);
                nxt_ra     = nxt_rd;
            end
            S_AEND: begin
                rsp_load              = 1'b1;
                rsp_next.start_block  = r_head;
                rsp_next.blocks_taken = CNT_W'(r_itm.need);
                rsp_next.words_used   = r_itm.rest;
                rsp_next.blocks_free  = r_free - CNT_W'(r_itm.need);
            end
            S_RWALK: begin
                mk_we  = 1'b1;
                mk_wa  = nxt_rd;
                nxt_ra = nxt_rd;
            end
            S_RLINK: begin
                nxt_we               = (r_free != '0);
                rsp_load             = 1'b1;
                rsp_next.blocks_free = r_free + r_itm.count;
            end
            S_INSP: begin
                rsp_load                = 1'b1;
                rsp_next.words_used     = mk_rd.used;
                rsp_next.chain_position = mk_rd.pos;
                rsp_next.next_of_block  = nxt_rd;
            end
            default: begin
                rsp_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_itm  <= i_cmd;
            r_k    <= CNT_W'(1);
            r_last <= i_cmd.first;
        end else if (r_state == S_AWALK || r_state == S_RWALK) begin
            r_k    <= k_nxt;
            r_last <= nxt_rd;
        end
        if (rsp_load) begin
            r_rsp <= rsp_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= BLK_W'(NUM_BLOCKS - 1);
            r_free      <= CNT_W'(NUM_BLOCKS);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_AEND) begin
                r_head <= nxt_rd;
                r_free <= r_free - CNT_W'(r_itm.need);
            end
            if (r_state == S_RLINK) begin
                if (r_free == '0) begin
                    r_head <= r_itm.first;
                end
                r_tail <= r_last;
                r_free <= r_free + r_itm.count;
            end
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/bcfl_checker.sv =====
`include "block_chain_free_list_allocator_unit_macros.svh"

module bcfl_checker import bcfl_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    logic err_fields_zero;
    logic rsp_wait;
    logic rsp_err;
    logic rsp_alloc;
    logic free_in_range;
    logic alloc_words_ok;

    assign err_fields_zero = (i_rsp.start_block == '0) && (i_rsp.blocks_taken == '0)
                          && (i_rsp.words_used == '0) && (i_rsp.chain_position == '0)
                          && (i_rsp.next_of_block == '0);
    assign rsp_wait        = i_rsp_valid && !i_rsp_ready;
    assign rsp_err         = i_rsp_valid && (i_rsp.status != ST_OK);
    assign rsp_alloc       = i_rsp_valid && (i_rsp.blocks_taken != '0);
    assign free_in_range   = (i_rsp.blocks_free <= CNT_W'(NUM_BLOCKS));
    assign alloc_words_ok  = (i_rsp.status == ST_OK) && (i_rsp.words_used != '0)
                          && (i_rsp.words_used <= WORDS_W'(BLOCK_WORDS));

    `BCFL_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, rsp_wait, i_rsp_valid && $stable(i_rsp))
    `BCFL_ASSERT_IMP(a_err_clean, i_clk, i_rst_n, rsp_err, err_fields_zero)
    `BCFL_ASSERT_IMP(a_free_bound, i_clk, i_rst_n, i_rsp_valid, free_in_range)
    `BCFL_ASSERT_IMP(a_alloc_words, i_clk, i_rst_n, rsp_alloc, alloc_words_ok)

endmodule

bind block_chain_free_list_allocator_unit bcfl_checker u_bcfl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);
